/* hw/rtl/vtdt_pkg.sv */
// Package for the vertex tuple dedup table: sizes, codes, slot layout and hash helpers.
`default_nettype none

package vtdt_pkg;

  // Table sizing
  localparam int TABLE_ENTRIES = 4096;
  localparam int INDEX_BITS    = 20;

  // Field widths
  localparam int POS_W      = INDEX_BITS;
  localparam int REF_W      = INDEX_BITS + 1;
  localparam int OUT_VIDX_W = 12;
  localparam int STATUS_W   = 2;

  // Internal widths: vertex index, fill count, hash slot address
  localparam int VIDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W  = VIDX_W + 1;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int EPOCH_W = 4;

  // Command codes
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STAT_FOUND   = 2'd0;
  localparam status_t STAT_ADDED   = 2'd1;
  localparam status_t STAT_FULL    = 2'd2;
  localparam status_t STAT_CLEARED = 2'd3;

  // Epoch zero marks a swept slot and is never live
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // One hash slot: live when its epoch matches the current one
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VIDX_W-1:0]  vidx;
    logic [POS_W-1:0]   pos;
    logic [REF_W-1:0]   tex;
    logic [REF_W-1:0]   nrm;
  } slot_t;

  localparam int SLOT_DW = $bits(slot_t);

  // h * 65599 + v, modulo 2^32, as shift-add
  function automatic logic [31:0] hash_mix(logic [31:0] h, logic [31:0] v);
    return (h << 16) + (h << 6) - h + v;
  endfunction

  // Fold a 32-bit hash down to a slot address
  function automatic logic [SLOT_W-1:0] hash_fold(logic [31:0] h);
    return h[31 -: SLOT_W] ^ h[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/vtdt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module vtdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/vertex_tuple_dedup_table_core.sv */
// Vertex tuple dedup table: hashed slot memory with linear probing and epoch clear.
// Lookup/insert: S_HASH reads the home slot, then S_PROBE reads further slots until a hit or a free slot;
//   one slot read per cycle, next item accepted at the edge ending the result strobe.
// Clear: result strobe the next cycle; every 15th clear wraps the epoch and starts a sweep.
// Sweep: after reset and on epoch wrap, every one of the SLOTS slots is marked swept, with busy high.
// Reset is synchronous, active low; the result receiver cannot stall.
`default_nettype none

module vertex_tuple_dedup_table_core
  import vtdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [POS_W-1:0]      in_position_index,
  input  logic [REF_W-1:0]      in_texcoord_ref,
  input  logic [REF_W-1:0]      in_normal_ref,
  output logic                  out_valid,
  output logic [OUT_VIDX_W-1:0] out_vertex_index,
  output logic [STATUS_W-1:0]   out_status
);

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Control registers
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SLOT_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [REF_W-1:0]      tex_r, tex_nxt;
  logic [REF_W-1:0]      nrm_r, nrm_nxt;
  logic [31:0]           h1_r, h1_nxt;
  logic [SLOT_W-1:0]     probe_addr_r, probe_addr_nxt;
  logic [SLOT_W-1:0]     data_addr_r, data_addr_nxt;
  logic [OUT_VIDX_W-1:0] out_vidx_r, out_vidx_nxt;
  status_t               out_status_r, out_status_nxt;

  // Slot RAM ports
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  slot_t                 wr_slot;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_DW-1:0]    rd_data;
  slot_t                 rd_slot;

  // Probe decode
  logic               accept;
  logic [SLOT_W-1:0]  home;
  logic               slot_live;
  logic               slot_hit;
  logic               tbl_full;
  logic [EPOCH_W-1:0] epoch_inc;

  vtdt_ram #(
    .WIDTH (SLOT_DW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_slot   = slot_t'(rd_data);
  assign accept    = start && (state_r == S_IDLE);
  assign home      = hash_fold(hash_mix(h1_r, 32'(nrm_r)));
  assign slot_live = (rd_slot.epoch == epoch_r);
  assign slot_hit  = slot_live && (rd_slot.pos == pos_r) && (rd_slot.tex == tex_r) &&
                     (rd_slot.nrm == nrm_r);
  assign tbl_full  = (cnt_r == CNT_W'(TABLE_ENTRIES));
  assign epoch_inc = epoch_r + EPOCH_W'(1);

  // Read address: home slot first, then consecutive slots
  assign rd_addr = (state_r == S_HASH) ? home : probe_addr_r;

  // Next-state and datapath
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    epoch_nxt      = epoch_r;
    sweep_addr_nxt = sweep_addr_r;
    out_valid_nxt  = 1'b0;
    pos_nxt        = pos_r;
    tex_nxt        = tex_r;
    nrm_nxt        = nrm_r;
    h1_nxt         = h1_r;
    probe_addr_nxt = probe_addr_r;
    data_addr_nxt  = data_addr_r;
    out_vidx_nxt   = out_vidx_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = sweep_addr_r;
    wr_slot        = '0;

    unique case (state_r)
      S_SWEEP: begin
        // Mark every slot swept, one per cycle
        wr_en          = 1'b1;
        wr_addr        = sweep_addr_r;
        wr_slot        = '0;
        sweep_addr_nxt = sweep_addr_r + SLOT_W'(1);
        if (sweep_addr_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_command) == CMD_CLEAR) begin
            out_valid_nxt  = 1'b1;
            out_vidx_nxt   = '0;
            out_status_nxt = STAT_CLEARED;
            cnt_nxt        = '0;
            if (epoch_inc == EPOCH_SWEPT) begin
              epoch_nxt      = EPOCH_FIRST;
              sweep_addr_nxt = '0;
              state_nxt      = S_SWEEP;
            end else begin
              epoch_nxt = epoch_inc;
            end
          end else begin
            pos_nxt   = in_position_index;
            tex_nxt   = in_texcoord_ref;
            nrm_nxt   = in_normal_ref;
            h1_nxt    = hash_mix(32'(in_position_index), 32'(in_texcoord_ref));
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        // Home slot read issued this cycle
        data_addr_nxt  = home;
        probe_addr_nxt = home + SLOT_W'(1);
        state_nxt      = S_PROBE;
      end

      S_PROBE: begin
        // Keep a read in flight on the next slot; drop it once resolved
        data_addr_nxt  = probe_addr_r;
        probe_addr_nxt = probe_addr_r + SLOT_W'(1);
        if (slot_hit) begin
          out_valid_nxt  = 1'b1;
          out_vidx_nxt   = OUT_VIDX_W'(rd_slot.vidx);
          out_status_nxt = STAT_FOUND;
          state_nxt      = S_IDLE;
        end else if (!slot_live) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (tbl_full) begin
            out_vidx_nxt   = '0;
            out_status_nxt = STAT_FULL;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = data_addr_r;
            wr_slot.epoch  = epoch_r;
            wr_slot.vidx   = cnt_r[VIDX_W-1:0];
            wr_slot.pos    = pos_r;
            wr_slot.tex    = tex_r;
            wr_slot.nrm    = nrm_r;
            cnt_nxt        = cnt_r + CNT_W'(1);
            out_vidx_nxt   = OUT_VIDX_W'(cnt_r[VIDX_W-1:0]);
            out_status_nxt = STAT_ADDED;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      cnt_r        <= '0;
      epoch_r      <= EPOCH_FIRST;
      sweep_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      epoch_r      <= epoch_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    tex_r        <= tex_nxt;
    nrm_r        <= nrm_nxt;
    h1_r         <= h1_nxt;
    probe_addr_r <= probe_addr_nxt;
    data_addr_r  <= data_addr_nxt;
    out_vidx_r   <= out_vidx_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_vidx_r;
  assign out_status       = out_status_r;

  // A new tuple gets the count before the insert, and the count steps by one
  a_added_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_ADDED) |->
      (out_vertex_index == OUT_VIDX_W'($past(cnt_r))) &&
      (cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1))))
    else $error("added vertex index does not follow fill count");

  // Full is reported only when the table really holds TABLE_ENTRIES tuples
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> tbl_full)
    else $error("table full reported below capacity");

  // A clear leaves an empty table
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_CLEARED) |-> (cnt_r == '0))
    else $error("fill count not zero after clear");

  // An accepted lookup leaves the idle state; a clear answers at once
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted beat produced neither work nor result");

  // Slot writes come only from the sweep or a resolved probe
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == S_SWEEP) || ((state_r == S_PROBE) && !slot_live && !tbl_full)))
    else $error("slot RAM written outside sweep or insert");

  // The live epoch is never the swept marker
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != EPOCH_SWEPT)
    else $error("live epoch equals swept marker");

endmodule

`default_nettype wire
